// File: hdl/lru_page_frame_stack_top_macros.svh
// Assertion macros used by the checker file of the LRU page frame stack.
// Depends on nothing; include by bare file name.
`ifndef LRU_PAGE_FRAME_STACK_TOP_MACROS_SVH
`define LRU_PAGE_FRAME_STACK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfs check failed");

`endif

// File: hdl/lpfs_pkg.sv
// Package of the LRU page frame stack: sizes, derived widths, width helpers.
// Depends on nothing; used by the interfaces, the top level and the checker.
package lpfs_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    // Fixed field widths of the channels
    localparam int PAGE_IN_W = 16;
    localparam int OCC_W     = 4;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = CNT_W + 1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Keep the low PAGE_BITS bits of an incoming page number
    function automatic page_t to_page(input logic [PAGE_IN_W-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[PAGE_BITS-1:0];
    endfunction

    // Fit a stored page into an output field
    function automatic logic [PAGE_IN_W-1:0] from_page(input page_t p);
        logic [63:0] w;
        w = 64'(p);
        return w[PAGE_IN_W-1:0];
    endfunction

    // Fit a count into the occupancy field
    function automatic logic [OCC_W-1:0] to_occ(input cnt_t c);
        logic [63:0] w;
        w = 64'(c);
        return w[OCC_W-1:0];
    endfunction

endpackage

// File: hdl/lpfs_in_if.sv
// Request channel of the LRU page frame stack: one page reference per transfer.
// Depends on lpfs_pkg for the field width.
interface lpfs_in_if;
    logic                           valid;
    logic                           ready;
    logic [lpfs_pkg::PAGE_IN_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

// File: hdl/lpfs_out_if.sv
// Result channel of the LRU page frame stack: one result per reference.
// Depends on lpfs_pkg for the field widths.
interface lpfs_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic                           evicted_valid;
    logic [lpfs_pkg::PAGE_IN_W-1:0] evicted_page;
    logic [lpfs_pkg::OCC_W-1:0]     occupancy;
    logic [lpfs_pkg::PAGE_IN_W-1:0] lru_page;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output occupancy, output lru_page, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input occupancy, input lru_page, output ready);
endinterface

// File: hdl/lpfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lpfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lru_page_frame_stack_top.sv
// LRU page frame stack over lpfs_pkg, lpfs_in_if, lpfs_out_if and lpfs_ram; slot 0 is least recent.
// IDLE takes a reference; SCAN reads slots upward from slot 0 until a match or the top;
// SHIFT slides the slots above a hit down, or on a miss on a full stack shifts FRAMES-1 slots;
// TOP writes the page and loads the result. One reference at a time: the next is taken only
// after the result loads, and TOP waits while a held result blocks the top write.
// Reset: asynchronous, active low; clears the count and control, slots stay undefined.
module lru_page_frame_stack_top (
    input  logic            clk,
    input  logic            rst_n,
    lpfs_in_if.sink         req,
    lpfs_out_if.source      rsp
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        TOP
    } state_t;

    // Control and result registers
    state_t                                 state_reg, state_next;
    lpfs_pkg::page_t                        page_reg, page_next;
    lpfs_pkg::cnt_t                         count_reg, count_next;
    lpfs_pkg::cnt_t                         new_count_reg, new_count_next;
    lpfs_pkg::page_t                        bottom_reg, bottom_next;
    lpfs_pkg::idx_t                         idx_reg, idx_next;
    lpfs_pkg::idx_t                         top_reg, top_next;
    logic                                   hit_reg, hit_next;
    logic                                   ev_valid_reg, ev_valid_next;
    lpfs_pkg::page_t                        ev_page_reg, ev_page_next;

    logic                                   out_valid_reg, out_valid_next;
    logic                                   out_hit_reg, out_hit_next;
    logic                                   out_ev_valid_reg, out_ev_valid_next;
    logic [lpfs_pkg::PAGE_IN_W-1:0]         out_ev_page_reg, out_ev_page_next;
    logic [lpfs_pkg::OCC_W-1:0]             out_occ_reg, out_occ_next;
    logic [lpfs_pkg::PAGE_IN_W-1:0]         out_lru_reg, out_lru_next;

    // RAM port signals
    logic                                   ram_we;
    lpfs_pkg::idx_t                         ram_waddr;
    lpfs_pkg::page_t                        ram_wdata;
    lpfs_pkg::idx_t                         ram_raddr;
    lpfs_pkg::page_t                        ram_rdata;

    // Scan and shift bookkeeping, compared in one extra bit so idx + 2 never wraps
    logic [lpfs_pkg::CMP_W-1:0]             cnt_ext;
    logic [lpfs_pkg::CMP_W-1:0]             idx_p1;
    logic [lpfs_pkg::CMP_W-1:0]             idx_p2;
    lpfs_pkg::cnt_t                         count_m1;
    logic                                   match;
    logic                                   last;
    logic                                   full;
    logic                                   out_free;

    lpfs_ram #(
        .WIDTH (lpfs_pkg::PAGE_BITS),
        .DEPTH (lpfs_pkg::FRAMES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_ext  = lpfs_pkg::CMP_W'(count_reg);
    assign idx_p1   = lpfs_pkg::CMP_W'(idx_reg) + lpfs_pkg::CMP_W'(1);
    assign idx_p2   = lpfs_pkg::CMP_W'(idx_reg) + lpfs_pkg::CMP_W'(2);
    assign count_m1 = count_reg - lpfs_pkg::CNT_W'(1);
    // During SCAN the read data belongs to slot idx_reg
    assign match    = (ram_rdata == page_reg);
    assign last     = (idx_p1 >= cnt_ext);
    assign full     = (count_reg == lpfs_pkg::CNT_W'(lpfs_pkg::FRAMES));
    // The result register can take a new result this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready         = (state_reg == IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.occupancy     = out_occ_reg;
    assign rsp.lru_page      = out_lru_reg;

    always_comb
    begin
        state_next        = state_reg;
        page_next         = page_reg;
        count_next        = count_reg;
        new_count_next    = new_count_reg;
        bottom_next       = bottom_reg;
        idx_next          = idx_reg;
        top_next          = top_reg;
        hit_next          = hit_reg;
        ev_valid_next     = ev_valid_reg;
        ev_page_next      = ev_page_reg;

        out_valid_next    = out_valid_reg;
        out_hit_next      = out_hit_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_ev_page_next  = out_ev_page_reg;
        out_occ_next      = out_occ_reg;
        out_lru_next      = out_lru_reg;

        // Default read: the slot after the current index, which both SCAN and
        // a SHIFT entered on a hit need next
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = idx_p1[lpfs_pkg::IDX_W-1:0];

        // Drop the held result once the sink takes it
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                ram_raddr = '0;
                if (req.valid)
                begin
                    page_next     = lpfs_pkg::to_page(req.page_number);
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                    if (count_reg == '0)
                    begin
                        // Empty stack: push straight into slot 0
                        top_next       = '0;
                        new_count_next = lpfs_pkg::CNT_W'(1);
                        state_next     = TOP;
                    end
                    else
                    begin
                        state_next = SCAN;
                    end
                end
            end

            SCAN:
            begin
                if (match)
                begin
                    hit_next       = 1'b1;
                    new_count_next = count_reg;
                    if (last)
                    begin
                        // Already on top: rewrite it in place
                        top_next   = count_m1[lpfs_pkg::IDX_W-1:0];
                        state_next = TOP;
                    end
                    else
                    begin
                        // Slide the slots above the hit down, starting at idx_reg
                        state_next = SHIFT;
                    end
                end
                else if (last)
                begin
                    hit_next = 1'b0;
                    if (full)
                    begin
                        // Evict the bottom and slide everything down from slot 0
                        ev_valid_next  = 1'b1;
                        ev_page_next   = bottom_reg;
                        new_count_next = count_reg;
                        idx_next       = '0;
                        ram_raddr      = lpfs_pkg::IDX_W'(1);
                        state_next     = SHIFT;
                    end
                    else
                    begin
                        top_next       = count_reg[lpfs_pkg::IDX_W-1:0];
                        new_count_next = count_reg + lpfs_pkg::CNT_W'(1);
                        state_next     = TOP;
                    end
                end
                else
                begin
                    idx_next = idx_p1[lpfs_pkg::IDX_W-1:0];
                end
            end

            SHIFT:
            begin
                // Read data is slot idx_reg + 1; move it down one place
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = idx_p2[lpfs_pkg::IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    bottom_next = ram_rdata;
                end
                if (idx_p2 < cnt_ext)
                begin
                    idx_next = idx_p1[lpfs_pkg::IDX_W-1:0];
                end
                else
                begin
                    top_next   = count_m1[lpfs_pkg::IDX_W-1:0];
                    state_next = TOP;
                end
            end

            TOP:
            begin
                // Hold here until the result register is free
                if (out_free)
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = top_reg;
                    ram_wdata         = page_reg;
                    count_next        = new_count_reg;
                    out_valid_next    = 1'b1;
                    out_hit_next      = hit_reg;
                    out_ev_valid_next = ev_valid_reg;
                    out_ev_page_next  = lpfs_pkg::from_page(ev_page_reg);
                    out_occ_next      = lpfs_pkg::to_occ(new_count_reg);
                    if (top_reg == '0)
                    begin
                        bottom_next  = page_reg;
                        out_lru_next = lpfs_pkg::from_page(page_reg);
                    end
                    else
                    begin
                        out_lru_next = lpfs_pkg::from_page(bottom_reg);
                    end
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers need no reset
    always_ff @(posedge clk)
    begin
        page_reg         <= page_next;
        new_count_reg    <= new_count_next;
        bottom_reg       <= bottom_next;
        idx_reg          <= idx_next;
        top_reg          <= top_next;
        hit_reg          <= hit_next;
        ev_valid_reg     <= ev_valid_next;
        ev_page_reg      <= ev_page_next;
        out_hit_reg      <= out_hit_next;
        out_ev_valid_reg <= out_ev_valid_next;
        out_ev_page_reg  <= out_ev_page_next;
        out_occ_reg      <= out_occ_next;
        out_lru_reg      <= out_lru_next;
    end

endmodule

// File: hdl/lpfs_checker.sv
// Port-level checks for the LRU page frame stack, attached to the top by bind.
// Depends on lpfs_pkg and lru_page_frame_stack_top_macros.svh.
`include "lru_page_frame_stack_top_macros.svh"

module lpfs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           hit,
    input logic                           evicted_valid,
    input logic [lpfs_pkg::PAGE_IN_W-1:0] evicted_page,
    input logic [lpfs_pkg::OCC_W-1:0]     occupancy,
    input logic [lpfs_pkg::PAGE_IN_W-1:0] lru_page
);

    `LPFS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(lru_page) && $stable(occupancy))
    `LPFS_ASSERT_NOW(a_evict_full, clk, rst_n, rsp_valid && evicted_valid, !hit && (occupancy == lpfs_pkg::OCC_W'(lpfs_pkg::FRAMES)))
    `LPFS_ASSERT_NOW(a_no_evict_zero, clk, rst_n, rsp_valid && !evicted_valid, evicted_page == '0)
    `LPFS_ASSERT_NOW(a_occ_range, clk, rst_n, rsp_valid, (occupancy != '0) && (occupancy <= lpfs_pkg::OCC_W'(lpfs_pkg::FRAMES)))

endmodule

bind lru_page_frame_stack_top lpfs_checker u_lpfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .hit           (rsp.hit),
    .evicted_valid (rsp.evicted_valid),
    .evicted_page  (rsp.evicted_page),
    .occupancy     (rsp.occupancy),
    .lru_page      (rsp.lru_page)
);

// File: test/lru_page_frame_stack_top_test.sv
// Testbench of the LRU page frame stack: directed reference table, then random page streams.
// Depends on lpfs_pkg, lpfs_in_if, lpfs_out_if and lru_page_frame_stack_top.
`timescale 1ns / 100ps

module lru_page_frame_stack_top_test;

    // One result as it leaves the block, at the widths of the result channel
    typedef struct packed {
        logic                           hit;
        logic                           evicted_valid;
        logic [lpfs_pkg::PAGE_IN_W-1:0] evicted_page;
        logic [lpfs_pkg::OCC_W-1:0]     occupancy;
        logic [lpfs_pkg::PAGE_IN_W-1:0] lru_page;
    } lru_result_t;

    // One row of the directed table: the page, and a typed-in result where one is given
    typedef struct packed {
        logic [lpfs_pkg::PAGE_IN_W-1:0] page_number;
        logic                           typed;
        lru_result_t                    result;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 18;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int MAX_LATENCY    = 2 * lpfs_pkg::FRAMES + 2;
    localparam int DRAIN_CYCLES   = 2 * MAX_LATENCY + 16;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Directed references. Typed-in results assume eight frames: fill, two hits at the bottom,
    // evict page zero (evicted_valid set with a zero page), hit at bottom, top and middle.
    localparam directed_row_t DIRECTED_REFS [DIRECTED_COUNT] = '{
        '{16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd1, 16'h0000}},
        '{16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd2, 16'h0000}},
        '{16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 4'd2, 16'hFFFF}},
        '{16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 4'd2, 16'h0000}},
        '{16'h0001, 1'b0, '0},
        '{16'h0002, 1'b0, '0},
        '{16'h0003, 1'b0, '0},
        '{16'h0004, 1'b0, '0},
        '{16'h0005, 1'b0, '0},
        '{16'h0006, 1'b0, '0},
        '{16'h0007, 1'b1, '{1'b0, 1'b1, 16'h0000, 4'd8, 16'hFFFF}},
        '{16'h5555, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 4'd8, 16'h0001}},
        '{16'hAAAA, 1'b0, '0},
        '{16'h0002, 1'b0, '0},
        '{16'h0002, 1'b0, '0},
        '{16'h0005, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'h0000, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    lpfs_in_if  req_if ();
    lpfs_out_if rsp_if ();

    lru_page_frame_stack_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Own copy of the stack: slot 0 is least recent, slot frame_count-1 most recent
    lpfs_pkg::page_t frame_stack [lpfs_pkg::FRAMES];
    int              frame_count;
    lru_result_t     pending_results [$];
    int              fail_count;
    int              results_seen;
    bit              source_bursting;
    bit              sink_bursting;

    // Apply one reference to the local stack and return the result it should give
    function automatic lru_result_t predict_reference(
        input logic [lpfs_pkg::PAGE_IN_W-1:0] page_number);
        lru_result_t     res;
        lpfs_pkg::page_t page;
        lpfs_pkg::page_t victim;
        int              hit_slot;
        int              k;
        page     = lpfs_pkg::page_t'(page_number);
        victim   = '0;
        hit_slot = -1;
        res      = '0;
        for (k = 0; k < frame_count; k++)
        begin
            if (hit_slot < 0 && frame_stack[k] == page)
                hit_slot = k;
        end
        if (hit_slot >= 0)
        begin
            // Close the gap above the old slot, then put the page on top
            res.hit = 1'b1;
            for (k = hit_slot; k + 1 < frame_count; k++)
                frame_stack[k] = frame_stack[k + 1];
            frame_stack[frame_count - 1] = page;
        end
        else if (frame_count == lpfs_pkg::FRAMES)
        begin
            res.evicted_valid = 1'b1;
            victim = frame_stack[0];
            for (k = 0; k + 1 < lpfs_pkg::FRAMES; k++)
                frame_stack[k] = frame_stack[k + 1];
            frame_stack[lpfs_pkg::FRAMES - 1] = page;
        end
        else
        begin
            frame_stack[frame_count] = page;
            frame_count++;
        end
        res.evicted_page = lpfs_pkg::PAGE_IN_W'(victim);
        res.occupancy    = lpfs_pkg::OCC_W'(frame_count);
        res.lru_page     = lpfs_pkg::PAGE_IN_W'(frame_stack[0]);
        return res;
    endfunction

    // Idle cycles before the next transfer on one side; none while that side is bursting
    function automatic int draw_gap(input bit bursting);
        if (bursting)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Offer one page reference, wait for the transfer, then record its expected result.
    // Keep valid high across back-to-back items: lower it only when a gap is drawn.
    task automatic send_reference(input logic [lpfs_pkg::PAGE_IN_W-1:0] page,
                                  input bit typed, input lru_result_t typed_result);
        int          gap;
        lru_result_t predicted;
        gap = draw_gap(source_bursting);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.page_number <= page;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        // Run the predictor on typed rows too, so that its stack stays in step
        predicted = predict_reference(page);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold reset once, at the start of the run
    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: draw a stall per result, take the transfer, compare with the oldest
    // expectation. Once, hold ready low for a long stretch so the block backs up.
    initial
    begin : result_sink
        int          gap;
        bit          held_off;
        lru_result_t got;
        lru_result_t want;
        held_off = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
                gap = draw_gap(sink_bursting);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_if.valid !== 1'b1);
            got.hit           = rsp_if.hit;
            got.evicted_valid = rsp_if.evicted_valid;
            got.evicted_page  = rsp_if.evicted_page;
            got.occupancy     = rsp_if.occupancy;
            got.lru_page      = rsp_if.lru_page;
            results_seen++;
            // Switch between stalling and taking every result now and then
            if (results_seen % 97 == 0)
                sink_bursting = ($urandom_range(0, 3) == 0);
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no reference pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                check_field("lru_page", 32'(want.lru_page), 32'(got.lru_page));
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either channel for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: directed table, then random segments drawn from small page pools
    initial
    begin : reference_source
        logic [lpfs_pkg::PAGE_IN_W-1:0] page_pool [16];
        logic [lpfs_pkg::PAGE_IN_W-1:0] page;
        int                             pool_size;
        int                             seg_len;
        int                             random_sent;
        int                             row;
        int                             k;
        fail_count      = 0;
        results_seen    = 0;
        source_bursting = 1'b0;
        sink_bursting   = 1'b0;
        frame_count     = 0;
        for (k = 0; k < lpfs_pkg::FRAMES; k++)
            frame_stack[k] = '0;
        req_if.valid       <= 1'b0;
        req_if.page_number <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (row = 0; row < DIRECTED_COUNT; row++)
            send_reference(DIRECTED_REFS[row].page_number, DIRECTED_REFS[row].typed,
                           DIRECTED_REFS[row].result);

        // Pools near the frame count give long runs of hits; larger pools keep evicting.
        // A share of fully random pages stirs in cold misses.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            seg_len   = $urandom_range(30, 90);
            pool_size = $urandom_range(3, 14);
            for (k = 0; k < pool_size; k++)
                page_pool[k] = lpfs_pkg::PAGE_IN_W'($urandom);
            source_bursting = ($urandom_range(0, 3) == 0);
            for (k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 15)
                    page = lpfs_pkg::PAGE_IN_W'($urandom);
                else
                    page = page_pool[$urandom_range(0, pool_size - 1)];
                send_reference(page, 1'b0, '0);
                random_sent++;
            end
        end
        req_if.valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lpfs_pkg.sv
hdl/lpfs_in_if.sv
hdl/lpfs_out_if.sv
hdl/lpfs_ram.sv
hdl/lru_page_frame_stack_top.sv
hdl/lpfs_checker.sv
test/lru_page_frame_stack_top_test.sv
